// ===== sv/m4inv_pkg.sv =====
// ----------------------------------------------------------------------------
// m4inv_pkg
// Shared constants and helper functions for the 4x4 matrix inverse block.
// ----------------------------------------------------------------------------
package m4inv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  // k-th of the four indexes 0..3 with one index skipped
  function automatic logic [1:0] skip_pick(input logic [1:0] skip, input logic [1:0] k);
    logic [2:0] v;
    v = (k < skip) ? {1'b0, k} : ({1'b0, k} + 3'd1);
    return v[1:0];
  endfunction

  // permutation of three columns: {odd, c2, c1, c0}
  function automatic logic [6:0] perm_cols(input logic [2:0] p);
    logic [6:0] r;
    case (p)
      3'd0:    r = {1'b0, 2'd2, 2'd1, 2'd0};
      3'd1:    r = {1'b1, 2'd1, 2'd2, 2'd0};
      3'd2:    r = {1'b1, 2'd2, 2'd0, 2'd1};
      3'd3:    r = {1'b0, 2'd0, 2'd2, 2'd1};
      3'd4:    r = {1'b0, 2'd1, 2'd0, 2'd2};
      3'd5:    r = {1'b1, 2'd0, 2'd1, 2'd2};
      default: r = {1'b0, 2'd2, 2'd1, 2'd0};
    endcase
    return r;
  endfunction

endpackage

// ===== sv/matrix4x4_inverse_top.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_inverse_top
// 4x4 fixed-point matrix inverse by cofactors, one shared add/subtract unit
// doing shift-add multiplies and restoring division under a small sequencer.
// ----------------------------------------------------------------------------
// loads: one element per cycle, ready only while loading; 16 elements per matrix
// after the 16th: six shift-add products per cofactor, then det from row 0 by four
// more multiplies, then one restoring division per result, held until taken
// the single wide adder serves every multiply and divide loop; no new matrix loads until all 16 results leave
// synchronous active-low reset clears the sequencer, counters and output valid
module matrix4x4_inverse_top
  import m4inv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((WORD_BITS+7)/8)*8-1:0]       in_tdata,   // element_value
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((WORD_BITS+4+7)/8)*8-1:0]     out_tdata,  // result_value, result_index
  output logic                                 out_tlast,
  output logic [1:0]                           out_tuser   // det_was_zero, saturated
);

  localparam int W   = WORD_BITS;
  localparam int CW  = 3*WORD_BITS + 3;
  localparam int XW  = 5*WORD_BITS + 2*FRAC_BITS + 8;
  localparam int BCW = $clog2(WORD_BITS + 1);
  localparam int OW  = ((WORD_BITS+4+7)/8)*8;

  typedef enum logic [11:0] {
    S_LOAD = 12'b000000000001,
    S_FA   = 12'b000000000010,
    S_FB   = 12'b000000000100,
    S_M1   = 12'b000000001000,
    S_FC   = 12'b000000010000,
    S_M2   = 12'b000000100000,
    S_DF   = 12'b000001000000,
    S_DM   = 12'b000010000000,
    S_DX   = 12'b000100000000,
    S_QL   = 12'b001000000000,
    S_QD   = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [W-1:0]   mat_r [16];
  logic [CW-1:0]  cof_r [16];
  logic [3:0]     cnt_r, cnt_nxt;
  logic [3:0]     idx_r, idx_nxt;
  logic [2:0]     perm_r, perm_nxt;
  logic [BCW-1:0] bit_r, bit_nxt;
  logic [XW-1:0]  acc_r, acc_nxt;
  logic [XW-1:0]  prod_r, prod_nxt;
  logic [XW-1:0]  mc_r, mc_nxt;
  logic [XW-1:0]  dmag_r, dmag_nxt;
  logic [W-1:0]   mp_r, mp_nxt;
  logic [W:0]     q_r, q_nxt;
  logic           dneg_r, dneg_nxt;
  logic           dz_r, dz_nxt;
  logic           qneg_r, qneg_nxt;
  logic           ov_r, ov_nxt;
  logic [W-1:0]   oval_r, oval_nxt;
  logic           osat_r, osat_nxt;

  logic [6:0]     pc;
  logic [1:0]     row, col, er, ec;
  logic [W-1:0]   elem;
  logic [3:0]     cof_addr;
  logic [CW-1:0]  cof_rd;
  logic [XW-1:0]  cof_x;
  logic [XW-1:0]  opa, opb, sum;
  logic           sub;
  logic           last_bit;
  logic           negt;
  logic           in_fire, out_fire, ge;
  logic [W:0]     qf;
  logic [W-1:0]   lim, qv;
  logic           sat;

  assign in_tready = (state_r == S_LOAD);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = ov_r && out_tready;

  assign row      = idx_r[3:2];
  assign col      = idx_r[1:0];
  assign pc       = perm_cols(perm_r);
  assign negt     = pc[6] ^ row[0] ^ col[0];
  assign last_bit = (bit_r == BCW'(W - 1));

  // element address for the current fetch
  always_comb begin
    er = 2'd0;
    ec = 2'd0;
    unique case (state_r)
      S_FA: begin
        er = skip_pick(col, 2'd0);
        ec = skip_pick(row, pc[1:0]);
      end
      S_FB: begin
        er = skip_pick(col, 2'd1);
        ec = skip_pick(row, pc[3:2]);
      end
      S_FC: begin
        er = skip_pick(col, 2'd2);
        ec = skip_pick(row, pc[5:4]);
      end
      S_DF: begin
        er = 2'd0;
        ec = col;
      end
      default: begin
        er = 2'd0;
        ec = 2'd0;
      end
    endcase
  end

  assign elem     = mat_r[{er, ec}];
  assign cof_addr = (state_r == S_DF) ? {col, 2'b00} : idx_r;
  assign cof_rd   = cof_r[cof_addr];
  assign cof_x    = {{(XW-CW){cof_rd[CW-1]}}, cof_rd};

  // shared add/subtract unit
  always_comb begin
    opa = acc_r;
    opb = mc_r;
    sub = 1'b0;
    unique case (state_r)
      S_M1: begin
        opa = prod_r;
        sub = last_bit;
      end
      S_M2: sub = last_bit ^ negt;
      S_DM: sub = last_bit;
      S_DX: begin
        opa = '0;
        opb = acc_r;
        sub = acc_r[XW-1];
      end
      S_QL: begin
        opa = '0;
        opb = cof_x << (2*FRAC_BITS);
        sub = cof_rd[CW-1];
      end
      S_QD: sub = 1'b1;
      default: sub = 1'b0;
    endcase
  end

  assign sum = opa + (sub ? ~opb : opb) + {{(XW-1){1'b0}}, sub};
  assign ge  = !sum[XW-1];
  assign qf  = {q_r[W-1:0], ge};
  assign lim = qneg_r ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign sat = qf[W] || (qf[W-1:0] > lim);
  assign qv  = sat ? lim : qf[W-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    perm_nxt  = perm_r;
    bit_nxt   = bit_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    mc_nxt    = mc_r;
    mp_nxt    = mp_r;
    dmag_nxt  = dmag_r;
    q_nxt     = q_r;
    dneg_nxt  = dneg_r;
    dz_nxt    = dz_r;
    qneg_nxt  = qneg_r;
    ov_nxt    = ov_r;
    oval_nxt  = oval_r;
    osat_nxt  = osat_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            state_nxt = S_FA;
            idx_nxt   = 4'd0;
            perm_nxt  = 3'd0;
            acc_nxt   = '0;
          end
        end
      end
      S_FA: begin
        mc_nxt    = {{(XW-W){elem[W-1]}}, elem};
        prod_nxt  = '0;
        state_nxt = S_FB;
      end
      S_FB: begin
        mp_nxt    = elem;
        bit_nxt   = '0;
        state_nxt = S_M1;
      end
      S_M1: begin
        if (mp_r[0]) prod_nxt = sum;
        mc_nxt  = mc_r << 1;
        mp_nxt  = mp_r >> 1;
        bit_nxt = bit_r + BCW'(1);
        if (last_bit) state_nxt = S_FC;
      end
      S_FC: begin
        mc_nxt    = prod_r;
        mp_nxt    = elem;
        bit_nxt   = '0;
        state_nxt = S_M2;
      end
      S_M2: begin
        if (mp_r[0]) acc_nxt = sum;
        mc_nxt  = mc_r << 1;
        mp_nxt  = mp_r >> 1;
        bit_nxt = bit_r + BCW'(1);
        if (last_bit) begin
          state_nxt = S_FA;
          if (perm_r == 3'd5) begin
            perm_nxt = 3'd0;
            acc_nxt  = '0;
            idx_nxt  = idx_r + 4'd1;
            if (idx_r == 4'd15) state_nxt = S_DF;
          end else begin
            perm_nxt = perm_r + 3'd1;
          end
        end
      end
      S_DF: begin
        mc_nxt    = cof_x;
        mp_nxt    = elem;
        bit_nxt   = '0;
        state_nxt = S_DM;
      end
      S_DM: begin
        if (mp_r[0]) acc_nxt = sum;
        mc_nxt  = mc_r << 1;
        mp_nxt  = mp_r >> 1;
        bit_nxt = bit_r + BCW'(1);
        if (last_bit) begin
          idx_nxt   = idx_r + 4'd1;
          state_nxt = (idx_r == 4'd3) ? S_DX : S_DF;
          if (idx_r == 4'd3) idx_nxt = 4'd0;
        end
      end
      S_DX: begin
        // zero determinant becomes one lsb of the word format
        dz_nxt = (acc_r == '0);
        if (acc_r == '0) begin
          dmag_nxt = {{(XW-1){1'b0}}, 1'b1} << (3*FRAC_BITS);
          dneg_nxt = 1'b0;
        end else begin
          dmag_nxt = sum;
          dneg_nxt = acc_r[XW-1];
        end
        state_nxt = S_QL;
      end
      S_QL: begin
        acc_nxt   = sum;
        qneg_nxt  = cof_rd[CW-1] ^ dneg_r;
        mc_nxt    = dmag_r << W;
        q_nxt     = '0;
        bit_nxt   = '0;
        state_nxt = S_QD;
      end
      S_QD: begin
        if (ge) acc_nxt = sum;
        q_nxt   = qf;
        mc_nxt  = mc_r >> 1;
        bit_nxt = bit_r + BCW'(1);
        if (bit_r == BCW'(W)) begin
          ov_nxt    = 1'b1;
          osat_nxt  = sat;
          oval_nxt  = qneg_r ? (~qv + {{(W-1){1'b0}}, 1'b1}) : qv;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_fire) begin
          ov_nxt    = 1'b0;
          idx_nxt   = idx_r + 4'd1;
          state_nxt = (idx_r == 4'd15) ? S_LOAD : S_QL;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= 4'd0;
      idx_r   <= 4'd0;
      perm_r  <= 3'd0;
      bit_r   <= '0;
      ov_r    <= 1'b0;
      dz_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      perm_r  <= perm_nxt;
      bit_r   <= bit_nxt;
      ov_r    <= ov_nxt;
      dz_r    <= dz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    mc_r   <= mc_nxt;
    mp_r   <= mp_nxt;
    dmag_r <= dmag_nxt;
    q_r    <= q_nxt;
    dneg_r <= dneg_nxt;
    qneg_r <= qneg_nxt;
    oval_r <= oval_nxt;
    osat_r <= osat_nxt;
    if (in_fire) mat_r[cnt_r] <= in_tdata[W-1:0];
    // final term of the sixth product only adds when the multiplier sign bit is set
    if (state_r == S_M2 && last_bit && perm_r == 3'd5)
      cof_r[idx_r] <= mp_r[0] ? sum[CW-1:0] : acc_r[CW-1:0];
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = OW'({idx_r, oval_r});
  assign out_tlast  = (idx_r == 4'd15);
  assign out_tuser  = {osat_r, dz_r};

  // assertions
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_sat_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] && !out_tdata[W-1] |-> out_tdata[W-2:0] == {(W-1){1'b1}})
    else $error("positive saturation without max value");

  a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("not back to loading after last result");

  a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == S_QD)
    else $error("result shown outside the divide step");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 4x4 fixed-point matrix inverse: streams matrices
// in row-major order, predicts the cofactor/determinant inverse exactly in wide
// integer arithmetic and checks every result transaction field by field.
// ----------------------------------------------------------------------------
module tb;
  import m4inv_pkg::*;

  localparam int FB        = FRAC_BITS_DEF;
  localparam int WB        = WORD_BITS_DEF;
  localparam int CYC_LIMIT = 1000000;

  typedef logic signed [255:0] wide_t;
  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  index;
    logic        last;
    logic        det_zero;
    logic        sat;
  } inv_elem_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  logic signed [31:0] elem_mem[16];
  int unsigned        elem_cnt;
  inv_elem_t          inverse_q[$];
  int unsigned        err_cnt;
  int unsigned        cyc_cnt;
  int unsigned        stall_left;
  bit                 quiet;

  matrix4x4_inverse_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic wide_t el(int r, int c);
    wide_t w;
    w = elem_mem[r * 4 + c];
    return w;
  endfunction

  // signed cofactor of element (col, row), i.e. adjugate entry (row, col)
  function automatic wide_t adj_entry(int row, int col);
    int    rs[3];
    int    cs[3];
    int    n;
    wide_t t;
    n = 0;
    for (int k = 0; k < 4; k++) if (k != col) begin rs[n] = k; n++; end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != row) begin cs[n] = k; n++; end
    t = el(rs[0], cs[0]) * (el(rs[1], cs[1]) * el(rs[2], cs[2])
                          - el(rs[1], cs[2]) * el(rs[2], cs[1]))
      - el(rs[0], cs[1]) * (el(rs[1], cs[0]) * el(rs[2], cs[2])
                          - el(rs[1], cs[2]) * el(rs[2], cs[0]))
      + el(rs[0], cs[2]) * (el(rs[1], cs[0]) * el(rs[2], cs[1])
                          - el(rs[1], cs[1]) * el(rs[2], cs[0]));
    return ((row + col) % 2 == 1) ? -t : t;
  endfunction

  task automatic predict_inverse();
    wide_t        adj[16];
    wide_t        det;
    logic [255:0] dmag;
    logic [255:0] num;
    logic [255:0] quo;
    logic [255:0] lim;
    bit           dzero;
    bit           neg;
    inv_elem_t    r;
    for (int i = 0; i < 16; i++) adj[i] = adj_entry(i / 4, i % 4);
    det = '0;
    for (int k = 0; k < 4; k++) det = det + el(0, k) * adj[k * 4];
    dzero = (det == 0);
    // singular matrix: determinant taken as one lsb
    if (dzero) det = wide_t'(1) <<< (3 * FB);
    dmag = det[255] ? -det : det;
    for (int i = 0; i < 16; i++) begin
      neg = adj[i][255] != det[255];
      num = adj[i][255] ? -adj[i] : adj[i];
      quo = (num << (2 * FB)) / dmag;
      lim = (256'(1) << (WB - 1)) - 1 + (neg ? 1 : 0);
      r.sat = quo > lim;
      if (r.sat) quo = lim;
      if (neg) quo = -quo;
      r.value    = quo[31:0];
      r.index    = i[3:0];
      r.last     = (i == 15);
      r.det_zero = dzero;
      inverse_q.push_back(r);
    end
  endtask

  task automatic send_element(logic [31:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    elem_mem[elem_cnt] = v;
    if (elem_cnt == 15) begin
      elem_cnt = 0;
      predict_inverse();
    end else begin
      elem_cnt++;
    end
  endtask

  task automatic send_matrix(logic [31:0] m[16]);
    for (int i = 0; i < 16; i++) send_element(m[i]);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
  endtask

  // two equal rows with the word extremes: singular and saturating
  task automatic test_singular();
    logic [31:0] m[16];
    m = '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'hffff_ffff,
          32'h0000_0001, 32'h0003_0000, 32'hfffe_0000, 32'h0000_8000,
          32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'hffff_ffff,
          32'h0000_0000, 32'h0002_0000, 32'h8000_0000, 32'h7fff_ffff};
    send_matrix(m);
  endtask

  // diagonal with 1.0, -1 lsb and the extremes: mixed overflow and underflow
  task automatic test_diagonal();
    logic [31:0] m[16];
    m = '{default: 32'h0};
    m[0]  = 32'h0001_0000;
    m[5]  = 32'hffff_ffff;
    m[10] = 32'h7fff_ffff;
    m[15] = 32'h8000_0000;
    send_matrix(m);
  endtask

  task automatic test_random(int n_mat);
    logic [31:0] m[16];
    int          kind;
    for (int j = 0; j < n_mat; j++) begin
      kind = $urandom_range(0, 3);
      for (int i = 0; i < 16; i++) begin
        case (kind)
          0: m[i] = $urandom;
          1: m[i] = $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
          default: m[i] = (i % 5 == 0) ? 32'h0001_0000 + $urandom_range(0, 32'hffff)
                                       : $urandom_range(0, 32'h1fff) - 32'h1000;
        endcase
      end
      // singular case: duplicate a row
      if (kind == 3) for (int i = 0; i < 4; i++) m[12 + i] = m[i];
      send_matrix(m);
      if (j == 2) wait_drained();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    elem_cnt  = 0;
    err_cnt   = 0;
    quiet     = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_singular();
    test_diagonal();
    test_random(6);
    quiet = 1'b1;
    test_random(2);
    wait_drained();
    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver stalls in random bursts
  initial out_tready = 1'b0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end
  initial stall_left = 0;

  always @(posedge clk) begin
    inv_elem_t got;
    inv_elem_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.value    = out_tdata[31:0];
      got.index    = out_tdata[35:32];
      got.last     = out_tlast;
      got.det_zero = out_tuser[0];
      got.sat      = out_tuser[1];
      if (inverse_q.size() == 0) begin
        $display("%t unexpected transaction: %h", $realtime, got);
        err_cnt++;
      end else begin
        want = inverse_q.pop_front();
        if (got.value !== want.value)
          $display("%t value: expected %h actual %h", $realtime, want.value, got.value);
        if (got.index !== want.index)
          $display("%t index: expected %0d actual %0d", $realtime, want.index, got.index);
        if (got.last !== want.last)
          $display("%t last: expected %b actual %b", $realtime, want.last, got.last);
        if (got.det_zero !== want.det_zero)
          $display("%t det_zero: expected %b actual %b", $realtime, want.det_zero,
                   got.det_zero);
        if (got.sat !== want.sat)
          $display("%t saturated: expected %b actual %b", $realtime, want.sat, got.sat);
        if (got !== want) err_cnt++;
      end
    end
  end

  initial cyc_cnt = 0;
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
sv/m4inv_pkg.sv
sv/matrix4x4_inverse_top.sv
tb/sv/tb.sv
